### design/dh64_pkg.sv
`timescale 1ns / 1ps

package dh64_pkg;

  // Item field widths
  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 3;
  localparam int unsigned LenW   = 31;
  localparam int unsigned HashW  = 64;

  // Configuration port
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  // Register indexes (byte address = 4 * index)
  localparam logic [ApbAddrW-1:0] RegSeedAddr = 3'd0;

  // MurmurHash2 constants
  localparam logic [WordW-1:0] MurmurM = 32'h5bd1e995;
  localparam int unsigned      MurmurR = 24;

  // Byte count of a full word
  localparam logic [CountW-1:0] FullCount = 3'd4;

  // Result handed from the hash core to the output register
  typedef struct packed {
    logic             valid;
    logic [HashW-1:0] hash;
  } dh64_res_t;

endpackage

### design/dh64_in_if.sv
`timescale 1ns / 1ps

interface dh64_in_if;
  import dh64_pkg::*;

  logic              valid;
  logic              ready;
  logic [WordW-1:0]  data_word;
  logic [CountW-1:0] byte_count;
  logic              last_word;
  logic [LenW-1:0]   total_length;

  modport source (
    output valid, data_word, byte_count, last_word, total_length,
    input  ready
  );

  modport sink (
    input  valid, data_word, byte_count, last_word, total_length,
    output ready
  );

endinterface

### design/dh64_out_if.sv
`timescale 1ns / 1ps

interface dh64_out_if;
  import dh64_pkg::*;

  logic             valid;
  logic             ready;
  logic [HashW-1:0] hash_value;

  modport source (
    output valid, hash_value,
    input  ready
  );

  modport sink (
    input  valid, hash_value,
    output ready
  );

endinterface

### design/dh64_mul.sv
`timescale 1ns / 1ps

// Shared multiplier: low word of a * MurmurM, registered.
module dh64_mul (
  input  logic                       clk_i,
  input  logic [dh64_pkg::WordW-1:0] a_i,
  output logic [dh64_pkg::WordW-1:0] p_o
);
  import dh64_pkg::*;

  logic [2*WordW-1:0] prod;
  logic [WordW-1:0]   p_q;

  assign prod = {{WordW{1'b0}}, a_i} * {{WordW{1'b0}}, MurmurM};

  always_ff @(posedge clk_i) begin
    p_q <= prod[WordW-1:0];
  end

  assign p_o = p_q;

endmodule

### design/dh64_core.sv
`timescale 1ns / 1ps

// Sequencer and accumulators for both hashes; one multiplier shared by all Murmur multiplies.
module dh64_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [dh64_pkg::WordW-1:0] seed_i,
  dh64_in_if.sink                    in_s,
  output dh64_pkg::dh64_res_t        res_o,
  input  logic                       res_ready_i
);
  import dh64_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MACC,
    ST_K1,
    ST_K2,
    ST_FOLD,
    ST_TL0,
    ST_TL1,
    ST_TL2,
    ST_AVAL,
    ST_OUT
  } state_e;

  function automatic logic [WordW-1:0] sext8(input logic [7:0] b);
    sext8 = {{(WordW-8){b[7]}}, b};
  endfunction

  state_e            state_q, state_d;
  logic              mid_q, mid_d;
  logic [2:0]        cnt_q, cnt_d;
  logic [WordW-1:0]  macc_q, macc_d;
  logic [WordW-1:0]  sacc_q, sacc_d;
  logic [WordW-1:0]  hm_q, hm_d;
  logic [WordW-1:0]  w_q, w_d;
  logic [CountW-1:0] n_q, n_d;
  logic              last_q, last_d;
  logic              lenz_q, lenz_d;

  logic [WordW-1:0]  mul_a;
  logic [WordW-1:0]  p;
  logic [CountW-1:0] n_in;
  logic              accept;
  logic [WordW-1:0]  len_ext;

  dh64_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .p_o   (p)
  );

  assign in_s.ready = (state_q == ST_IDLE);
  assign accept     = in_s.valid && in_s.ready;
  assign len_ext    = {1'b0, in_s.total_length};
  // non-last words and counts above four fold as a full word
  assign n_in = (!in_s.last_word || in_s.byte_count > FullCount) ? FullCount
                                                                 : in_s.byte_count;

  always_comb begin
    state_d = state_q;
    mid_d   = mid_q;
    cnt_d   = cnt_q;
    macc_d  = macc_q;
    sacc_d  = sacc_q;
    hm_d    = hm_q;
    w_d     = w_q;
    n_d     = n_q;
    last_d  = last_q;
    lenz_d  = lenz_q;
    mul_a   = macc_q;
    res_o.valid = 1'b0;
    res_o.hash  = {macc_q, lenz_q ? {WordW{1'b0}} : sacc_q};

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          w_d    = in_s.data_word;
          n_d    = n_in;
          last_d = in_s.last_word;
          lenz_d = (in_s.total_length == '0);
          cnt_d  = '0;
          mid_d  = 1'b1;
          if (!mid_q) begin
            macc_d = seed_i ^ len_ext;
            sacc_d = len_ext;
          end
          if (n_in == FullCount) begin
            state_d = ST_MACC;
          end else if (n_in == '0) begin
            state_d = ST_AVAL;
          end else begin
            state_d = ST_TL0;
          end
        end
      end
      ST_MACC: begin
        mul_a   = macc_q;
        sacc_d  = sacc_q + {16'b0, w_q[15:0]};
        state_d = ST_K1;
      end
      ST_K1: begin
        hm_d    = p;
        mul_a   = w_q;
        sacc_d  = (sacc_q << 16) ^ {5'b0, w_q[31:16], 11'b0} ^ sacc_q;
        state_d = ST_K2;
      end
      ST_K2: begin
        mul_a   = p ^ (p >> MurmurR);
        sacc_d  = sacc_q + (sacc_q >> 11);
        state_d = ST_FOLD;
      end
      ST_FOLD: begin
        macc_d  = p ^ hm_q;
        cnt_d   = '0;
        state_d = last_q ? ST_AVAL : ST_IDLE;
      end
      ST_TL0: begin
        case (n_q)
          3'd1:    mul_a = macc_q ^ {24'b0, w_q[7:0]};
          3'd2:    mul_a = macc_q ^ {16'b0, w_q[15:0]};
          default: mul_a = macc_q ^ {8'b0, w_q[23:0]};
        endcase
        sacc_d  = sacc_q + ((n_q == 3'd1) ? sext8(w_q[7:0]) : {16'b0, w_q[15:0]});
        state_d = ST_TL1;
      end
      ST_TL1: begin
        macc_d = p;
        case (n_q)
          3'd1:    sacc_d = sacc_q ^ (sacc_q << 10);
          3'd2:    sacc_d = sacc_q ^ (sacc_q << 11);
          default: sacc_d = sacc_q ^ (sacc_q << 16) ^ (sext8(w_q[23:16]) << 18);
        endcase
        state_d = ST_TL2;
      end
      ST_TL2: begin
        case (n_q)
          3'd1:    sacc_d = sacc_q + (sacc_q >> 1);
          3'd2:    sacc_d = sacc_q + (sacc_q >> 17);
          default: sacc_d = sacc_q + (sacc_q >> 11);
        endcase
        cnt_d   = '0;
        state_d = ST_AVAL;
      end
      ST_AVAL: begin
        cnt_d = cnt_q + 3'd1;
        case (cnt_q)
          3'd0: begin
            mul_a  = macc_q ^ (macc_q >> 13);
            sacc_d = sacc_q ^ (sacc_q << 3);
          end
          3'd1: begin
            macc_d = p ^ (p >> 15);
            sacc_d = sacc_q + (sacc_q >> 5);
          end
          3'd2:    sacc_d = sacc_q ^ (sacc_q << 4);
          3'd3:    sacc_d = sacc_q + (sacc_q >> 17);
          3'd4:    sacc_d = sacc_q ^ (sacc_q << 25);
          default: begin
            sacc_d  = sacc_q + (sacc_q >> 6);
            state_d = ST_OUT;
          end
        endcase
      end
      ST_OUT: begin
        res_o.valid = 1'b1;
        if (res_ready_i) begin
          mid_d   = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mid_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      mid_q   <= mid_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    macc_q <= macc_d;
    sacc_q <= sacc_d;
    hm_q   <= hm_d;
    w_q    <= w_d;
    n_q    <= n_d;
    last_q <= last_d;
    lenz_q <= lenz_d;
  end

endmodule

### design/dual_hash_64.sv
`timescale 1ns / 1ps

// dual_hash_64: MurmurHash2 and SuperFastHash of a byte string that arrives as
// little-endian 32-bit words (first byte in bits 7:0), four bytes per item
// except the last, which carries 0 to 4. The last item yields one 64-bit
// result: Murmur in 63:32, SuperFastHash in 31:0 (0 for an empty string).
// Single tail bytes are sign-extended for SuperFastHash. The Murmur seed sits
// at APB byte address 0 (reset 0) and is sampled on the first item of each
// string; write it only while the block is idle.
// Rate: one item at a time. A full word passes the MACC, K1, K2 and FOLD
// steps before the next ready; the final item adds 6 avalanche steps and a
// hand-off step. A last word of 1 to 3 bytes takes the TL0 to TL2 steps in
// place of the full-word ones, one of 0 bytes neither. The pace is set by the
// single registered 32x32 multiplier: each word needs three multiplies by the
// Murmur constant, two of them dependent; SuperFastHash steps run beside it.
// The result waits in an output register, so the core carries on while the
// sink stalls until it has a new result to hand over.
module dual_hash_64 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  dh64_in_if.sink                       in_s,
  dh64_out_if.source                    out_m,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dh64_pkg::ApbAddrW-1:0] paddr,
  input  logic [dh64_pkg::ApbDataW-1:0] pwdata,
  output logic [dh64_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);
  import dh64_pkg::*;

  // config register
  logic [WordW-1:0] seed_q;
  logic             cfg_wr;
  logic             sel_seed;

  // result path
  dh64_res_t        res;
  logic             res_ready;
  logic             out_valid_q;
  logic [HashW-1:0] out_hash_q;

  // APB: no wait states, one register at index 0
  assign pready   = 1'b1;
  assign sel_seed = (paddr[ApbAddrW-1:2] == RegSeedAddr[ApbAddrW-1:2]);
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign prdata   = sel_seed ? seed_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cfg_wr && sel_seed) begin
      seed_q <= pwdata;
    end
  end

  dh64_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seed_i      (seed_q),
    .in_s        (in_s),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  // output register: takes a new result whenever it is empty or being drained
  assign res_ready = !out_valid_q || out_m.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_m.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && res_ready) begin
      out_hash_q <= res.hash;
    end
  end

  assign out_m.valid      = out_valid_q;
  assign out_m.hash_value = out_hash_q;

  // core works on one item at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_s.valid && in_s.ready |=> !in_s.ready)
    else $error("core ready again right after taking an item");

  // a word that is not last never produces a result straight away
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_s.valid && in_s.ready && !in_s.last_word |=> !res.valid)
    else $error("result raised after a non-final word");

  // a stalled core result holds until the output register takes it
  a_res_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid && !res_ready |=> res.valid && $stable(res.hash))
    else $error("core result dropped or changed while stalled");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

// Checks dual_hash_64 against a cycle-free predictor of MurmurHash2 and
// SuperFastHash. Items and results are tracked at the two stream handshakes.
// The Murmur seed is reprogrammed between phases over APB and read back each time.

module testbench;
  import dh64_pkg::*;

  localparam int ClkPeriod    = 8;
  localparam int ResetCycles  = 8;
  localparam int StallLimit   = 3000;  // cycles with no stream handshake at all
  localparam int SettleCycles = 24;    // twice the run of the longest item
  localparam int PhaseWords   = 567;

  // ---------------------------------------------------------------------------
  // Predictor plus result checker. It folds every accepted word into its own
  // copy of both hash states and queues one 64-bit hash per string.
  // ---------------------------------------------------------------------------
  class hash_scoreboard;
    logic [WordW-1:0] seed;
    logic [WordW-1:0] murmur_h;
    logic [WordW-1:0] sfh_h;
    bit               in_string;
    logic [HashW-1:0] expected_hashes[$];
    int unsigned      n_errors;
    int unsigned      n_words;
    int unsigned      n_hashes;

    function new();
      seed      = '0;
      murmur_h  = '0;
      sfh_h     = '0;
      in_string = 1'b0;
      n_errors  = 0;
      n_words   = 0;
      n_hashes  = 0;
    endfunction

    // Full four-byte word for both hashes.
    function void fold_full(logic [WordW-1:0] w);
      logic [WordW-1:0] k;
      logic [WordW-1:0] mix;
      k = w * MurmurM;
      k ^= k >> MurmurR;
      k = k * MurmurM;
      murmur_h = (murmur_h * MurmurM) ^ k;

      sfh_h += {16'h0, w[15:0]};
      mix = ({16'h0, w[31:16]} << 11) ^ sfh_h;
      sfh_h = (sfh_h << 16) ^ mix;
      sfh_h += sfh_h >> 11;
    endfunction

    // One to three tail bytes; single bytes act as signed char for SFH.
    function void fold_tail(logic [WordW-1:0] w, logic [CountW-1:0] n);
      case (n)
        3'd3: begin
          murmur_h ^= {8'h0, w[23:0]};
          murmur_h = murmur_h * MurmurM;
          sfh_h += {16'h0, w[15:0]};
          sfh_h ^= sfh_h << 16;
          sfh_h ^= {{24{w[23]}}, w[23:16]} << 18;
          sfh_h += sfh_h >> 11;
        end
        3'd2: begin
          murmur_h ^= {16'h0, w[15:0]};
          murmur_h = murmur_h * MurmurM;
          sfh_h += {16'h0, w[15:0]};
          sfh_h ^= sfh_h << 11;
          sfh_h += sfh_h >> 17;
        end
        3'd1: begin
          murmur_h ^= {24'h0, w[7:0]};
          murmur_h = murmur_h * MurmurM;
          sfh_h += {{24{w[7]}}, w[7:0]};
          sfh_h ^= sfh_h << 10;
          sfh_h += sfh_h >> 1;
        end
        default: ;
      endcase
    endfunction

    function void absorb_word(logic [WordW-1:0] w, logic [CountW-1:0] cnt, logic last,
                              logic [LenW-1:0] len);
      logic [CountW-1:0] n;
      logic [WordW-1:0]  h;
      logic [WordW-1:0]  s;
      n_words++;
      // first word of a string: length and seed are taken here only
      if (!in_string) begin
        murmur_h  = seed ^ {1'b0, len};
        sfh_h     = {1'b0, len};
        in_string = 1'b1;
      end
      n = (cnt > FullCount) ? FullCount : cnt;
      if (!last) begin
        fold_full(w);
        return;
      end
      if (n == FullCount) fold_full(w);
      else fold_tail(w, n);

      h = murmur_h;
      h ^= h >> 13;
      h = h * MurmurM;
      h ^= h >> 15;

      s = sfh_h;
      s ^= s << 3;
      s += s >> 5;
      s ^= s << 4;
      s += s >> 17;
      s ^= s << 25;
      s += s >> 6;
      // zero-length check looks at the length field of the last word
      if (len == '0) s = '0;

      in_string = 1'b0;
      expected_hashes.push_back({h, s});
    endfunction

    function void check_hash(logic [HashW-1:0] got);
      logic [HashW-1:0] want;
      if (expected_hashes.size() == 0) begin
        $display("%0t: unexpected hash_value %h", $time, got);
        n_errors++;
        return;
      end
      want = expected_hashes.pop_front();
      n_hashes++;
      if (got !== want) begin
        $display("%0t: hash_value mismatch: expected %h, got %h", $time, want, got);
        n_errors++;
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset, channels, APB
  // ---------------------------------------------------------------------------
  logic clk_i;
  logic rst_ni;

  dh64_in_if  in_if ();
  dh64_out_if out_if ();

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  dual_hash_64 i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_s    (in_if),
    .out_m   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  hash_scoreboard sb = new();

  int src_idle_pct;  // chance in 100 that the sender holds off before an item
  int snk_idle_pct;  // chance in 100 per cycle that the receiver stalls
  int stall_cycles;

  initial clk_i = 1'b0;
  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Receiver: ready redrawn every falling edge, one assignment per step.
  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Monitor at the rising edge: feed the predictor, check results, track the
  // seed register, and run the no-progress watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        sb.absorb_word(in_if.data_word, in_if.byte_count, in_if.last_word,
                       in_if.total_length);
      end
      if (out_if.valid && out_if.ready) begin
        sb.check_hash(out_if.hash_value);
      end
      if (psel && penable && pwrite && pready && paddr == RegSeedAddr) begin
        sb.seed = pwdata;
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= StallLimit) begin
        $display("%0t: no handshake for %0d cycles, %0d hashes outstanding", $time,
                 stall_cycles, sb.expected_hashes.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // One item on the input channel. valid stays high between back-to-back items;
  // here it is only lowered when a gap is drawn.
  task automatic send_word(input logic [WordW-1:0] w, input logic [CountW-1:0] cnt,
                           input logic last, input logic [LenW-1:0] len);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.data_word    <= w;
    in_if.byte_count   <= cnt;
    in_if.last_word    <= last;
    in_if.total_length <= len;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Stop sending and hold off until every queued hash has come out.
  task automatic wait_all_hashed();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (sb.expected_hashes.size() != 0) @(posedge clk_i);
  endtask

  // Same, then let the core run out any word still in flight.
  task automatic settle();
    wait_all_hashed();
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // APB write of the seed, then a read-back at the same address.
  task automatic write_seed(input logic [ApbDataW-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RegSeedAddr;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== value) begin
      $display("%0t: murmur_seed read-back: expected %h, got %h", $time, value, prdata);
      sb.n_errors++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [WordW-1:0] pick_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return $urandom() | 32'h8080_8080;  // sign bits set in every byte
      default: return $urandom();
    endcase
  endfunction

  // One string. Mostly well-formed with random content; the rest are broken
  // sequences: arbitrary byte counts, length fields that disagree, zero length
  // on a last word that carries data.
  task automatic send_random_string(inout int sent);
    int               kind;
    int               n_bytes;
    int               n_full;
    int               n_words;
    logic [LenW-1:0]  len;
    logic [CountW-1:0] cnt;
    logic [31:0]      r;
    kind = $urandom_range(99);
    if (kind < 80) begin
      // mostly short strings, now and then a long one
      n_bytes = ($urandom_range(19) == 0) ? $urandom_range(300) : $urandom_range(40);
      len     = LenW'(n_bytes);
      n_full  = n_bytes / 4;
      cnt     = CountW'(n_bytes % 4);
      // a multiple of four ends either on a full last word or on an empty one
      if (cnt == 0 && n_full != 0 && $urandom_range(1)) begin
        n_full--;
        cnt = FullCount;
      end
      for (int i = 0; i < n_full; i++) begin
        send_word(pick_word(), FullCount, 1'b0, len);
        sent++;
      end
      send_word(pick_word(), cnt, 1'b1, len);
      sent++;
    end else begin
      n_words = $urandom_range(6, 1);
      for (int i = 0; i < n_words; i++) begin
        r   = $urandom();
        len = ($urandom_range(7) == 0) ? '0 : r[LenW-1:0];
        cnt = CountW'($urandom_range(7));
        send_word(pick_word(), cnt, (i == n_words - 1), len);
        sent++;
      end
    end
  endtask

  task automatic run_random_phase(input int n_items);
    int  sent;
    bit  paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < n_items) begin
      send_random_string(sent);
      // once per phase the sender waits for every hash to drain
      if (!paused && sent >= n_items / 2) begin
        wait_all_hashed();
        paused = 1'b1;
      end
    end
  endtask

  // Short directed set, run at the reset seed.
  task automatic run_directed();
    send_word(32'h0000_0000, 3'd0, 1'b1, 31'd0);          // empty string
    send_word(32'hffff_ff80, 3'd1, 1'b1, 31'd1);          // negative single byte
    send_word(32'h0000_007f, 3'd1, 1'b1, 31'd1);          // positive single byte
    send_word(32'h0000_ffff, 3'd2, 1'b1, 31'd2);
    send_word(32'h0080_7f01, 3'd3, 1'b1, 31'd3);          // negative third byte
    send_word(32'hff7f_ffff, 3'd3, 1'b1, 31'd3);          // junk in unused byte
    send_word(32'hffff_ffff, FullCount, 1'b1, 31'd4);     // full last word
    send_word(32'hffff_ffff, FullCount, 1'b0, 31'd8);
    send_word(32'h0000_0000, FullCount, 1'b1, 31'd8);
    send_word(32'h1234_5678, FullCount, 1'b0, 31'd4);
    send_word(32'hdead_beef, 3'd0, 1'b1, 31'd4);          // empty last word
    send_word(32'hffff_ffff, 3'd7, 1'b1, 31'd4);          // count above four
    send_word(32'ha5a5_a5a5, 3'd0, 1'b0, 31'd6);          // middle word, count ignored
    send_word(32'h0000_c3c3, 3'd2, 1'b1, 31'd6);
    send_word(32'h00ff_ffff, 3'd3, 1'b1, 31'h7fff_ffff);  // longest length
    send_word(32'h00ab_cdef, 3'd3, 1'b1, 31'd0);          // zero length, with data
    send_word(32'h1111_1111, FullCount, 1'b0, 31'd5);     // first word sets the length
    send_word(32'h0000_00ff, 3'd1, 1'b1, 31'h7fff_ffff);
    send_word(32'h8080_8080, 3'd5, 1'b0, 31'd8);
    send_word(32'h7f7f_7f7f, FullCount, 1'b1, 31'd0);     // zero length on last word
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed set at the default seed, then three random
  // phases, each with its own seed and its own idling pattern.
  // ---------------------------------------------------------------------------
  initial begin
    logic [ApbDataW-1:0] phase_seed;
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.data_word    = '0;
    in_if.byte_count   = '0;
    in_if.last_word    = 1'b0;
    in_if.total_length = '0;
    out_if.ready       = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    stall_cycles       = 0;
    src_idle_pct       = 0;
    snk_idle_pct       = 0;

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    run_directed();
    settle();

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          phase_seed   = '1;
          src_idle_pct = 25;
          snk_idle_pct = 53;
        end
        1: begin
          phase_seed   = $urandom();
          src_idle_pct = 53;
          snk_idle_pct = 25;
        end
        default: begin
          phase_seed   = '0;
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      write_seed(phase_seed);
      run_random_phase(PhaseWords);
      settle();
    end

    $display("covered %0d words and %0d hashes over seeds 0, all-ones, random and 0",
             sb.n_words, sb.n_hashes);
    $display("with sender and receiver stalls, an idle drain and broken strings");
    if (sb.n_errors == 0 && sb.expected_hashes.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
